// ----- rtl/core/srfw_pkg.sv -----
// Shared types and constants of the selective-repeat fetch window.
`timescale 1ns / 1ps

package srfw_pkg;

   // Field widths
   localparam int TOTAL_W    = 30;
   localparam int IDX_W      = 21;
   localparam int LEN_W      = 13;
   localparam int SLOT_OUT_W = 6;
   localparam int KIND_W     = 3;
   localparam int TYPE_W     = 2;
   localparam int NUM_W      = 31;
   localparam int DIV_CNT_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Input item kinds
   localparam logic [TYPE_W-1:0] REQ_TICK    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ARRIVE  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_DELIVER = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_FETCH     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DELIVERED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ORDER_ERR = 3'd4;

   // Register index, taken from address bit 2
   localparam logic CSR_TOTAL_BYTES = 1'b0;

   typedef enum logic [1:0] {
      SLOT_NOT_SENT = 2'd0,
      SLOT_SENT     = 2'd1,
      SLOT_ACKED    = 2'd2
   } slot_status_type;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [IDX_W-1:0]      index;
      logic [TOTAL_W-1:0]    offset;
      logic [LEN_W-1:0]      length;
      logic [SLOT_OUT_W-1:0] slot;
   } result_type;

endpackage

// ----- rtl/core/selective_repeat_fetch_window.sv -----
// Receive-side window of a selective-repeat file fetch, with its sequencer and shared multiplier.
`timescale 1ns / 1ps

// Usage:
// - Program total_bytes over the CSR port at address 0. The block then runs
//   a reciprocal division (busy high) to find the segment count and the
//   length of the last segment.
// - An item is taken when start is high and busy is low; req_type selects a
//   request tick, a data arrival (req_start_offset) or an in-order deliver.
// - Each result shows on the rsp_ ports for one cycle with rsp_valid high;
//   rsp_last_of_run marks the final result of an item. Results leave through
//   a one-deep holding register, so each is shown when the next is found or at the flush.
// - Arrival: a division on the shared multiplier, then a check step and a
//   flush step; its one result is sent out from the flush step.
// - Tick: one window slot visited per step from the head (up to
//   WINDOW_SLOTS), then a closing check and a flush. Deliver: one popped
//   segment per step, then a closing check and a flush; an ordering
//   error ends the walk and goes straight to the flush.
// - The receiver cannot stall; the block never holds a result back.
// - Synchronous reset clears the window, the delivered and segment counts and total_bytes.

module selective_repeat_fetch_window #(
   parameter int WINDOW_SLOTS  = 32,
   parameter int SEGMENT_BYTES = 1000
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   output logic                                         busy,
   input  logic [srfw_pkg::TYPE_W-1:0]                  req_type,
   input  logic [srfw_pkg::TOTAL_W-1:0]                 req_start_offset,
   output logic                                         rsp_valid,
   output logic [srfw_pkg::KIND_W-1:0]                  rsp_result_kind,
   output logic [srfw_pkg::IDX_W-1:0]                   rsp_segment_index,
   output logic [srfw_pkg::TOTAL_W-1:0]                 rsp_request_offset,
   output logic [srfw_pkg::LEN_W-1:0]                   rsp_segment_length,
   output logic [srfw_pkg::SLOT_OUT_W-1:0]              rsp_slot_index,
   output logic                                         rsp_last_of_run,
   input  logic                                         csr_psel,
   input  logic                                         csr_penable,
   input  logic                                         csr_pwrite,
   input  logic [srfw_pkg::CSR_ADDR_W-1:0]              csr_paddr,
   input  logic [srfw_pkg::CSR_DATA_W-1:0]              csr_pwdata,
   output logic [srfw_pkg::CSR_DATA_W-1:0]              csr_prdata,
   output logic                                         csr_pready
);

   localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);
   localparam int SB_W   = $clog2(SEGMENT_BYTES + 1);

   localparam int TOTAL_W = srfw_pkg::TOTAL_W;
   localparam int IDX_W   = srfw_pkg::IDX_W;
   localparam int LEN_W   = srfw_pkg::LEN_W;
   localparam int NUM_W   = srfw_pkg::NUM_W;
   localparam int DCNT_W  = srfw_pkg::DIV_CNT_W;

   // Reciprocal of the segment size, exact for every 30-bit dividend
   localparam int RECIP_SH = TOTAL_W + $clog2(SEGMENT_BYTES);
   localparam int PROD_W   = RECIP_SH + TOTAL_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_SH) + 64'(SEGMENT_BYTES) - 64'd1) / 64'(SEGMENT_BYTES);
   localparam logic [TOTAL_W:0]   RECIP     = (TOTAL_W+1)'(RECIP_FULL);
   localparam logic [TOTAL_W:0]   SB_MUL    = (TOTAL_W+1)'(SEGMENT_BYTES);

   localparam logic [LEN_W-1:0]   SB_LEN    = LEN_W'(SEGMENT_BYTES);
   localparam logic [TOTAL_W-1:0] SB_OFF    = TOTAL_W'(SEGMENT_BYTES);
   localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(WINDOW_SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ARRIVE,
      ST_TICK,
      ST_DELIVER,
      ST_FLUSH
   } state_type;

   // Sequencer and divider registers
   state_type                   state_ff,      state_in;
   logic                        div_cfg_ff,    div_cfg_in;
   logic [DCNT_W-1:0]           div_cnt_ff,    div_cnt_in;
   logic [TOTAL_W-1:0]          dvd_ff,        dvd_in;
   logic [TOTAL_W-1:0]          quo_ff,        quo_in;
   logic [SB_W-1:0]             rem_ff,        rem_in;
   logic [PROD_W-1:0]           prod_ff,       prod_in;
   logic [TOTAL_W-1:0]          start_off_ff,  start_off_in;

   // Configuration and derived file geometry
   logic [TOTAL_W-1:0]          total_ff,      total_in;
   logic [TOTAL_W-1:0]          all_ff,        all_in;
   logic [LEN_W-1:0]            last_len_ff,   last_len_in;

   // Window state
   logic [SLOT_W-1:0]           head_ff,       head_in;
   logic [IDX_W-1:0]            dc_ff,         dc_in;
   logic [TOTAL_W-1:0]          dc_off_ff,     dc_off_in;
   srfw_pkg::slot_status_type   status_ff [WINDOW_SLOTS];
   srfw_pkg::slot_status_type   status_in [WINDOW_SLOTS];
   logic [IDX_W-1:0]            seg_ff    [WINDOW_SLOTS];
   logic [IDX_W-1:0]            seg_in    [WINDOW_SLOTS];
   logic [LEN_W-1:0]            len_ff    [WINDOW_SLOTS];
   logic [LEN_W-1:0]            len_in    [WINDOW_SLOTS];

   // Tick walk
   logic [CNT_W-1:0]            walk_cnt_ff,   walk_cnt_in;
   logic [SLOT_W-1:0]           walk_pos_ff,   walk_pos_in;
   logic [TOTAL_W-1:0]          walk_off_ff,   walk_off_in;

   // Holding register and result output
   logic                        pend_valid_ff, pend_valid_in;
   srfw_pkg::result_type        pend_ff,       pend_in;
   logic                        rsp_valid_ff,  rsp_valid_in;
   srfw_pkg::result_type        rsp_ff,        rsp_in;
   logic                        rsp_last_ff,   rsp_last_in;

   // Next-state logic
   always_comb begin
      logic [TOTAL_W-1:0]     mul_a;
      logic [TOTAL_W:0]       mul_b;
      logic [PROD_W-1:0]      mul_out;
      logic [TOTAL_W-1:0]     quo_slice;
      logic [TOTAL_W-1:0]     rem_full;
      logic [SB_W-1:0]        rem_next;
      logic [NUM_W-1:0]       tick_num;
      logic [NUM_W-1:0]       arr_num;
      logic [NUM_W-1:0]       arr_dist;
      logic [SLOT_W:0]        pos_sum;
      logic [SLOT_W:0]        pos_wrap;
      logic [SLOT_W-1:0]      arr_pos;
      logic                   arr_ok;
      logic [IDX_W-1:0]       dc_next;
      logic                   new_valid;
      srfw_pkg::result_type   new_res;
      logic                   csr_wr;

      state_in      = state_ff;
      div_cfg_in    = div_cfg_ff;
      div_cnt_in    = div_cnt_ff;
      dvd_in        = dvd_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      prod_in       = prod_ff;
      start_off_in  = start_off_ff;
      total_in      = total_ff;
      all_in        = all_ff;
      last_len_in   = last_len_ff;
      head_in       = head_ff;
      dc_in         = dc_ff;
      dc_off_in     = dc_off_ff;
      status_in     = status_ff;
      seg_in        = seg_ff;
      len_in        = len_ff;
      walk_cnt_in   = walk_cnt_ff;
      walk_pos_in   = walk_pos_ff;
      walk_off_in   = walk_off_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      new_valid     = 1'b0;
      new_res       = '0;

      // Shared multiplier: dividend times reciprocal, then quotient times segment size
      quo_slice = prod_ff[RECIP_SH +: TOTAL_W];
      mul_a     = (div_cnt_ff == '0) ? dvd_ff : quo_slice;
      mul_b     = (div_cnt_ff == '0) ? RECIP : SB_MUL;
      mul_out   = {{(PROD_W-TOTAL_W){1'b0}}, mul_a} *
                  {{(PROD_W-TOTAL_W-1){1'b0}}, mul_b};
      rem_full  = dvd_ff - prod_ff[TOTAL_W-1:0];
      rem_next  = rem_full[SB_W-1:0];

      // Segment numbers under the tick walk and the arrival check
      tick_num = NUM_W'(dc_ff) + NUM_W'(walk_cnt_ff) + NUM_W'(1);
      arr_num  = NUM_W'(quo_ff) + NUM_W'(1);
      arr_dist = arr_num - NUM_W'(dc_ff) - NUM_W'(1);
      pos_sum  = {1'b0, arr_dist[SLOT_W-1:0]} + {1'b0, head_ff};
      pos_wrap = pos_sum - (SLOT_W+1)'(WINDOW_SLOTS);
      arr_pos  = (pos_sum >= (SLOT_W+1)'(WINDOW_SLOTS)) ? pos_wrap[SLOT_W-1:0]
                                                          : pos_sum[SLOT_W-1:0];
      arr_ok   = (arr_num > NUM_W'(dc_ff)) &&
                 (arr_num <= NUM_W'(dc_ff) + NUM_W'(WINDOW_SLOTS)) &&
                 (arr_num <= NUM_W'(all_ff));
      dc_next  = dc_ff + IDX_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_type)
                  srfw_pkg::REQ_TICK: begin
                     walk_cnt_in = '0;
                     walk_pos_in = head_ff;
                     walk_off_in = dc_off_ff;
                     state_in    = ST_TICK;
                  end
                  srfw_pkg::REQ_ARRIVE: begin
                     dvd_in       = req_start_offset;
                     start_off_in = req_start_offset;
                     quo_in       = '0;
                     rem_in       = '0;
                     div_cnt_in   = '0;
                     div_cfg_in   = 1'b0;
                     state_in     = ST_DIVIDE;
                  end
                  srfw_pkg::REQ_DELIVER: begin
                     state_in = ST_DELIVER;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Division by the segment size in three steps
         ST_DIVIDE: begin
            div_cnt_in = div_cnt_ff + DCNT_W'(1);
            if (div_cnt_ff == '0) begin
               prod_in = mul_out;
            end else if (div_cnt_ff == DCNT_W'(1)) begin
               quo_in  = quo_slice;
               prod_in = mul_out;
            end else begin
               rem_in = rem_next;
               if (div_cfg_ff) begin
                  all_in      = quo_ff + TOTAL_W'(rem_next != '0);
                  last_len_in = (rem_next == '0) ? SB_LEN : LEN_W'(rem_next);
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_ARRIVE;
               end
            end
         end

         // Arrival: window and ack check, one result
         ST_ARRIVE: begin
            new_valid = 1'b1;
            if (arr_ok && (status_ff[arr_pos] != srfw_pkg::SLOT_ACKED)) begin
               status_in[arr_pos] = srfw_pkg::SLOT_ACKED;
               new_res.kind       = srfw_pkg::KIND_ACCEPTED;
               new_res.index      = arr_num[IDX_W-1:0];
               new_res.offset     = start_off_ff - TOTAL_W'(rem_ff);
               new_res.length     = (arr_num == NUM_W'(all_ff)) ? last_len_ff : SB_LEN;
               new_res.slot       = srfw_pkg::SLOT_OUT_W'(arr_pos);
            end else begin
               new_res.kind  = srfw_pkg::KIND_DROPPED;
               new_res.index = arr_num[IDX_W-1:0];
            end
            state_in = ST_FLUSH;
         end

         // Tick: one window slot per cycle from the head
         ST_TICK: begin
            if ((walk_cnt_ff == CNT_W'(WINDOW_SLOTS)) || (tick_num > NUM_W'(all_ff))) begin
               state_in = ST_FLUSH;
            end else begin
               seg_in[walk_pos_ff] = tick_num[IDX_W-1:0];
               len_in[walk_pos_ff] = (tick_num == NUM_W'(all_ff)) ? last_len_ff : SB_LEN;
               if (status_ff[walk_pos_ff] != srfw_pkg::SLOT_ACKED) begin
                  status_in[walk_pos_ff] = srfw_pkg::SLOT_SENT;
                  new_valid      = 1'b1;
                  new_res.kind   = srfw_pkg::KIND_FETCH;
                  new_res.index  = tick_num[IDX_W-1:0];
                  new_res.offset = walk_off_ff;
                  new_res.length = len_in[walk_pos_ff];
                  new_res.slot   = srfw_pkg::SLOT_OUT_W'(walk_pos_ff);
               end
               walk_pos_in = (walk_pos_ff == SLOT_LAST) ? '0 : walk_pos_ff + SLOT_W'(1);
               walk_off_in = walk_off_ff + SB_OFF;
               walk_cnt_in = walk_cnt_ff + CNT_W'(1);
            end
         end

         // Deliver: pop acked segments at the head, one per cycle
         ST_DELIVER: begin
            if ((status_ff[head_ff] != srfw_pkg::SLOT_ACKED) ||
                (TOTAL_W'(dc_ff) >= all_ff)) begin
               state_in = ST_FLUSH;
            end else begin
               status_in[head_ff] = srfw_pkg::SLOT_NOT_SENT;
               head_in   = (head_ff == SLOT_LAST) ? '0 : head_ff + SLOT_W'(1);
               dc_in     = dc_next;
               dc_off_in = (dc_next == '0) ? '0 : dc_off_ff + SB_OFF;
               new_valid     = 1'b1;
               new_res.index = dc_next;
               new_res.slot  = srfw_pkg::SLOT_OUT_W'(head_ff);
               if (dc_next != seg_ff[head_ff]) begin
                  new_res.kind = srfw_pkg::KIND_ORDER_ERR;
                  state_in     = ST_FLUSH;
               end else begin
                  new_res.kind   = srfw_pkg::KIND_DELIVERED;
                  new_res.offset = dc_off_ff;
                  new_res.length = len_ff[head_ff];
               end
            end
         end

         // Last held result goes out marked as end of run
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = pend_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new result pushes the held one out
      if (new_valid) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = pend_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = new_res;
      end

      // Register write restarts the geometry division
      csr_wr = csr_psel && csr_penable && csr_pwrite;
      if (csr_wr && (csr_paddr[2] == srfw_pkg::CSR_TOTAL_BYTES)) begin
         total_in   = csr_pwdata[TOTAL_W-1:0];
         dvd_in     = csr_pwdata[TOTAL_W-1:0];
         quo_in     = '0;
         rem_in     = '0;
         div_cnt_in = '0;
         div_cfg_in = 1'b1;
         state_in   = ST_DIVIDE;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_ff      <= '0;
         all_ff        <= '0;
         last_len_ff   <= SB_LEN;
         head_ff       <= '0;
         dc_ff         <= '0;
         dc_off_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < WINDOW_SLOTS; k++) begin
            status_ff[k] <= srfw_pkg::SLOT_NOT_SENT;
            seg_ff[k]    <= '0;
            len_ff[k]    <= '0;
         end
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         all_ff        <= all_in;
         last_len_ff   <= last_len_in;
         head_ff       <= head_in;
         dc_ff         <= dc_in;
         dc_off_ff     <= dc_off_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         status_ff     <= status_in;
         seg_ff        <= seg_in;
         len_ff        <= len_in;
      end
      div_cfg_ff   <= div_cfg_in;
      div_cnt_ff   <= div_cnt_in;
      dvd_ff       <= dvd_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      prod_ff      <= prod_in;
      start_off_ff <= start_off_in;
      walk_cnt_ff  <= walk_cnt_in;
      walk_pos_ff  <= walk_pos_in;
      walk_off_ff  <= walk_off_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Ports
   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_ff.kind;
   assign rsp_segment_index  = rsp_ff.index;
   assign rsp_request_offset = rsp_ff.offset;
   assign rsp_segment_length = rsp_ff.length;
   assign rsp_slot_index     = rsp_ff.slot;
   assign rsp_last_of_run    = rsp_last_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == srfw_pkg::CSR_TOTAL_BYTES)
                       ? srfw_pkg::CSR_DATA_W'(total_ff) : '0;

endmodule
